### hw/rtl/cfc_pkg.sv
// shared types and constants for the cascaded fir convolution block
// used by cfc_ctrl, cfc_datapath and cascaded_fir_convolution; no dependencies
package cfc_pkg;

  localparam int IN_W         = 16;
  localparam int OUT_W        = 38;
  localparam int FIRST_REG_W  = 40;
  localparam int SECOND_REG_W = 56;
  localparam int CFG_DATA_W   = 56;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND = 1'b1;

  localparam logic [FIRST_REG_W-1:0]  FIRST_TAPS_RST  = 40'h01_0203_0201;
  localparam logic [SECOND_REG_W-1:0] SECOND_TAPS_RST = 56'h01_0000_0000_0001;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_SUM1,
    ST_MUL2,
    ST_SUM2
  } state_t;

  typedef struct packed {
    logic load_sample;
    logic load_zero;
    logic mul1;
    logic sum1;
    logic mul2;
    logic sum2;
    logic final_beat;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

### hw/rtl/cfc_ctrl.sv
// sequencer for the cascade: one pass of four steps per sample and per flush slot
// depends on cfc_pkg
module cfc_ctrl #(
  parameter int FLUSH_STEPS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_block_end,
  output logic             in_stall,
  input  cfc_pkg::status_t status,
  output cfc_pkg::cmd_t    cmd,
  output cfc_pkg::state_t  state
);

  localparam int CNT_W = $clog2(FLUSH_STEPS + 1);

  cfc_pkg::state_t  state_r, state_nxt;
  logic             flushing_r, flushing_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cfc_pkg::ST_IDLE;
      flushing_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      flushing_r <= flushing_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    flushing_nxt = flushing_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      cfc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          flushing_nxt    = in_block_end;
          cnt_nxt         = CNT_W'(FLUSH_STEPS);
          state_nxt       = cfc_pkg::ST_MUL1;
        end
      end
      cfc_pkg::ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = cfc_pkg::ST_SUM1;
      end
      cfc_pkg::ST_SUM1: begin
        cmd.sum1  = 1'b1;
        state_nxt = cfc_pkg::ST_MUL2;
      end
      cfc_pkg::ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = cfc_pkg::ST_SUM2;
      end
      cfc_pkg::ST_SUM2: begin
        // hold here until the output register can take the beat
        if (status.out_free) begin
          cmd.sum2 = 1'b1;
          if (flushing_r && cnt_r != '0) begin
            cmd.load_zero = 1'b1;
            cnt_nxt       = cnt_r - CNT_W'(1);
            state_nxt     = cfc_pkg::ST_MUL1;
          end else begin
            cmd.final_beat = flushing_r;
            cmd.clear      = flushing_r;
            flushing_nxt   = 1'b0;
            state_nxt      = cfc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = cfc_pkg::ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

### hw/rtl/cfc_datapath.sv
// tap registers, delay lines, product lanes, adders and output register
// depends on cfc_pkg; driven by commands from cfc_ctrl
module cfc_datapath #(
  parameter int FIRST_TAPS   = 5,
  parameter int SECOND_TAPS  = 7,
  parameter int COEF_WIDTH   = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cfc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [cfc_pkg::IN_W-1:0]     in_sample,
  input  cfc_pkg::cmd_t                       cmd,
  output cfc_pkg::status_t                    status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cfc_pkg::OUT_W-1:0]    out_filtered,
  output logic                                out_final_out
);

  localparam int P1W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int Y1W = P1W + $clog2(FIRST_TAPS);
  localparam int P2W = Y1W + COEF_WIDTH;
  localparam int Y2W = P2W + $clog2(SECOND_TAPS);

  logic [cfc_pkg::FIRST_REG_W-1:0]  taps1_r;
  logic [cfc_pkg::SECOND_REG_W-1:0] taps2_r;

  logic signed [SAMPLE_WIDTH-1:0] x0_r;
  logic signed [SAMPLE_WIDTH-1:0] d1_r [FIRST_TAPS-1];
  logic signed [Y1W-1:0]          d2_r [SECOND_TAPS-1];
  logic signed [P1W-1:0]          p1_r [FIRST_TAPS];
  logic signed [Y1W-1:0]          y1_r;
  logic signed [P2W-1:0]          p2_r [SECOND_TAPS];
  logic signed [cfc_pkg::OUT_W-1:0] filtered_r;
  logic                           final_r;
  logic                           out_valid_r, out_valid_nxt;

  logic signed [COEF_WIDTH-1:0]   c1 [FIRST_TAPS];
  logic signed [COEF_WIDTH-1:0]   c2 [SECOND_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] x1 [FIRST_TAPS];
  logic signed [Y1W-1:0]          x2 [SECOND_TAPS];
  logic signed [Y1W-1:0]          y1_nxt;
  logic signed [Y2W-1:0]          y2_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps1_r <= cfc_pkg::FIRST_TAPS_RST;
      taps2_r <= cfc_pkg::SECOND_TAPS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        cfc_pkg::REG_FIRST:  taps1_r <= cfg_data[cfc_pkg::FIRST_REG_W-1:0];
        cfc_pkg::REG_SECOND: taps2_r <= cfg_data[cfc_pkg::SECOND_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < FIRST_TAPS; i++) begin
      c1[i] = taps1_r[i*COEF_WIDTH +: COEF_WIDTH];
      x1[i] = (i == 0) ? x0_r : d1_r[(i == 0) ? 0 : i-1];
    end
    for (int i = 0; i < SECOND_TAPS; i++) begin
      c2[i] = taps2_r[i*COEF_WIDTH +: COEF_WIDTH];
      x2[i] = (i == 0) ? y1_r : d2_r[(i == 0) ? 0 : i-1];
    end
  end

  always_comb begin
    y1_nxt = '0;
    for (int i = 0; i < FIRST_TAPS; i++) begin
      y1_nxt = y1_nxt + Y1W'(p1_r[i]);
    end
    y2_nxt = '0;
    for (int i = 0; i < SECOND_TAPS; i++) begin
      y2_nxt = y2_nxt + Y2W'(p2_r[i]);
    end
  end

  // sample, delay lines and product lanes
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      x0_r <= in_sample[SAMPLE_WIDTH-1:0];
    end else if (cmd.load_zero) begin
      x0_r <= '0;
    end
    if (cmd.mul1) begin
      for (int i = 0; i < FIRST_TAPS; i++) begin
        p1_r[i] <= P1W'(c1[i]) * P1W'(x1[i]);
      end
    end
    if (cmd.sum1) begin
      y1_r <= y1_nxt;
    end
    if (cmd.mul2) begin
      for (int i = 0; i < SECOND_TAPS; i++) begin
        p2_r[i] <= P2W'(c2[i]) * P2W'(x2[i]);
      end
    end
    if (cmd.sum2) begin
      filtered_r <= cfc_pkg::OUT_W'(y2_nxt);
      final_r    <= cmd.final_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < FIRST_TAPS-1; i++) d1_r[i] <= '0;
      for (int i = 0; i < SECOND_TAPS-1; i++) d2_r[i] <= '0;
    end else begin
      if (cmd.sum1) begin
        d1_r[0] <= x0_r;
        for (int i = 1; i < FIRST_TAPS-1; i++) d1_r[i] <= d1_r[i-1];
      end
      if (cmd.mul2) begin
        d2_r[0] <= y1_r;
        for (int i = 1; i < SECOND_TAPS-1; i++) d2_r[i] <= d2_r[i-1];
      end
    end
  end

  // output beat register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.sum2) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_filtered    = filtered_r;
  assign out_final_out   = final_r;

endmodule

### hw/rtl/cascaded_fir_convolution.sv
// cascaded two-stage fir doing full linear convolution of a sample block
// top level; depends on cfc_pkg, cfc_ctrl and cfc_datapath
//
// input beats (in_sample, in_block_end) are taken on in_valid with in_stall low.
// each sample gives one output beat (out_filtered, out_final_out). a sample with
// in_block_end set is followed by (FIRST_TAPS-1)+(SECOND_TAPS-1) more beats, ten
// at the defaults, computed with zero input; the last one has out_final_out set,
// and both delay lines are cleared after it.
// every output beat takes one pass of the shared sequencer: first-stage
// products, first-stage sum, second-stage products, second-stage sum. a sample
// is accepted only when the sequencer is idle, so the next sample waits until
// the pass is through; the beat is registered by the second-stage sum step. a
// block-end sample holds the sequencer through its own pass and all flush passes.
// the output register holds a beat while out_stall is high; the sequencer then
// waits at its last step, and a new sample may be taken while the last beat
// still waits.
// cfg writes (cfg_index 0: first-stage taps, 1: second-stage taps) are taken
// every cycle and must only come while the block is idle.
// reset (rst_n low, synchronous) restores the default taps, clears the delay
// lines and drops out_valid.
module cascaded_fir_convolution #(
  parameter int FIRST_TAPS   = 5,
  parameter int SECOND_TAPS  = 7,
  parameter int COEF_WIDTH   = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [cfc_pkg::IN_W-1:0]  in_sample,
  input  logic                             in_block_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [cfc_pkg::OUT_W-1:0] out_filtered,
  output logic                             out_final_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int FLUSH_STEPS = (FIRST_TAPS - 1) + (SECOND_TAPS - 1);

  cfc_pkg::cmd_t    cmd;
  cfc_pkg::status_t status;
  cfc_pkg::state_t  state;

  assign cfg_ready = 1'b1;

  cfc_ctrl #(
    .FLUSH_STEPS(FLUSH_STEPS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_block_end(in_block_end),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd),
    .state       (state)
  );

  cfc_datapath #(
    .FIRST_TAPS  (FIRST_TAPS),
    .SECOND_TAPS (SECOND_TAPS),
    .COEF_WIDTH  (COEF_WIDTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_sample    (in_sample),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered),
    .out_final_out(out_final_out)
  );

`ifndef ASSERT_OFF
  // an accepted sample keeps the input side closed on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // a pending output beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum2 |-> (!out_valid || !out_stall))
    else $error("output register overwritten");

  // delay lines are cleared only together with the final beat
  a_clear_final: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (cmd.sum2 && cmd.final_beat && state == cfc_pkg::ST_SUM2))
    else $error("delay lines cleared outside a block end");
`endif

endmodule

### test/cfc_check_pkg.sv
// scoreboard for the cascaded fir convolution test: a bit-true cascade predictor
// and a queue of owed output beats; depends on cfc_pkg only
package cfc_check_pkg;

  localparam int FIRST_N     = 5;
  localparam int SECOND_N    = 7;
  localparam int COEF_W      = 8;
  localparam int FLUSH_BEATS = (FIRST_N - 1) + (SECOND_N - 1);

  typedef struct packed {
    logic signed [cfc_pkg::OUT_W-1:0] filtered;
    logic                             final_out;
  } beat_t;

  class conv_scoreboard;
    logic [cfc_pkg::FIRST_REG_W-1:0]  first_taps;
    logic [cfc_pkg::SECOND_REG_W-1:0] second_taps;
    longint                           first_line[FIRST_N-1];
    longint                           second_line[SECOND_N-1];
    beat_t                            owed_beats[$];
    int                               errors;

    function new();
      first_taps  = cfc_pkg::FIRST_TAPS_RST;
      second_taps = cfc_pkg::SECOND_TAPS_RST;
      foreach (first_line[i]) first_line[i] = 0;
      foreach (second_line[i]) second_line[i] = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [cfc_pkg::CFG_IDX_W-1:0] idx,
                          logic [cfc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        cfc_pkg::REG_FIRST:  first_taps  = data[cfc_pkg::FIRST_REG_W-1:0];
        cfc_pkg::REG_SECOND: second_taps = data[cfc_pkg::SECOND_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint tap(logic [63:0] bank, int i);
      logic signed [COEF_W-1:0] c;
      c = bank[i*COEF_W +: COEF_W];
      return c;
    endfunction

    // one sample through both stages, delay lines shifted
    function longint cascade_step(longint s);
      longint y1;
      longint y2;
      int     i;
      y1 = tap(64'(first_taps), 0) * s;
      for (i = 1; i < FIRST_N; i++) y1 += tap(64'(first_taps), i) * first_line[i-1];
      for (i = FIRST_N - 2; i > 0; i--) first_line[i] = first_line[i-1];
      first_line[0] = s;
      y2 = tap(64'(second_taps), 0) * y1;
      for (i = 1; i < SECOND_N; i++) y2 += tap(64'(second_taps), i) * second_line[i-1];
      for (i = SECOND_N - 2; i > 0; i--) second_line[i] = second_line[i-1];
      second_line[0] = y1;
      return y2;
    endfunction

    function void note_sample(logic signed [cfc_pkg::IN_W-1:0] s, logic block_end);
      beat_t  b;
      int     k;
      longint y;
      y           = cascade_step(longint'(s));
      b.filtered  = y[cfc_pkg::OUT_W-1:0];
      b.final_out = 1'b0;
      owed_beats.push_back(b);
      if (block_end) begin
        for (k = 0; k < FLUSH_BEATS; k++) begin
          y           = cascade_step(0);
          b.filtered  = y[cfc_pkg::OUT_W-1:0];
          b.final_out = (k == FLUSH_BEATS - 1);
          owed_beats.push_back(b);
        end
        foreach (first_line[i]) first_line[i] = 0;
        foreach (second_line[i]) second_line[i] = 0;
      end
    endfunction

    function void check_beat(logic signed [cfc_pkg::OUT_W-1:0] filtered, logic final_out);
      beat_t b;
      if (owed_beats.size() == 0) begin
        $display("%0t: unexpected beat, filtered %0d final_out %0b", $time, filtered,
                 final_out);
        errors++;
        return;
      end
      b = owed_beats.pop_front();
      if (b.filtered !== filtered) begin
        $display("%0t: filtered expected %0d actual %0d", $time, b.filtered, filtered);
        errors++;
      end
      if (b.final_out !== final_out) begin
        $display("%0t: final_out expected %0b actual %0b", $time, b.final_out, final_out);
        errors++;
      end
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction
  endclass

endpackage

### test/cascaded_fir_convolution_test.sv
// top of the cascaded fir convolution test: clock, reset, sample and tap drivers,
// output stall generator and watchdog; depends on cfc_pkg, cfc_check_pkg and cascaded_fir_convolution
module cascaded_fir_convolution_test;

  localparam int WATCHDOG_LIMIT = 3000;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic signed [cfc_pkg::IN_W-1:0]  in_sample = '0;
  logic                             in_block_end = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [cfc_pkg::OUT_W-1:0] out_filtered;
  logic                             out_final_out;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [cfc_pkg::CFG_IDX_W-1:0]    cfg_index = cfc_pkg::REG_FIRST;
  logic [cfc_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  logic                             calm = 1'b1;
  int                               stall_hold = 0;
  int                               quiet_cycles = 0;
  cfc_check_pkg::conv_scoreboard    board = new();

  cascaded_fir_convolution u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_block_end (in_block_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered),
    .out_final_out(out_final_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic send_sample(logic signed [cfc_pkg::IN_W-1:0] s, logic block_end);
    int r;
    int gap;
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_block_end <= block_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_sample(s, block_end);
    r = $urandom_range(0, 99);
    if (calm || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [cfc_pkg::CFG_IDX_W-1:0] idx,
                           logic [cfc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold off input until every owed beat is out, then let the sequencer drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_beat(out_filtered, out_final_out);
    if (calm) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 12);
    end else begin
      out_stall  <= 1'b1;
      stall_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                 : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                             count;
    int                             len;
    int                             k;
    int                             p;
    logic [63:0]                    rnd;
    logic [cfc_pkg::CFG_DATA_W-1:0] word;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default taps, back to back
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(-16'sh0001, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh5555, 1'b1);
    send_sample(16'shaaaa, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    settle();

    // most negative taps; bits above the first register are dropped
    calm <= 1'b0;
    write_reg(cfc_pkg::REG_FIRST, 56'hff_ff80_8080_8080);
    write_reg(cfc_pkg::REG_SECOND, 56'h80_8080_8080_8080);
    for (k = 0; k < 5; k++) send_sample(-16'sh8000, k == 4);
    send_sample(16'sh7fff, 1'b1);
    settle();

    // most positive taps
    write_reg(cfc_pkg::REG_FIRST, 56'h00_007f_7f7f_7f7f);
    write_reg(cfc_pkg::REG_SECOND, 56'h7f_7f7f_7f7f_7f7f);
    for (k = 0; k < 3; k++) send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b1);
    settle();

    // zero taps
    write_reg(cfc_pkg::REG_FIRST, '0);
    write_reg(cfc_pkg::REG_SECOND, '0);
    for (k = 0; k < 3; k++) begin
      rnd = {$urandom, $urandom};
      send_sample(rnd[cfc_pkg::IN_W-1:0], k == 2);
    end
    settle();

    // random taps, random blocks
    for (p = 0; p < 4; p++) begin
      rnd  = {$urandom, $urandom};
      word = rnd[cfc_pkg::CFG_DATA_W-1:0];
      write_reg(cfc_pkg::REG_FIRST, word);
      rnd  = {$urandom, $urandom};
      word = rnd[cfc_pkg::CFG_DATA_W-1:0];
      write_reg(cfc_pkg::REG_SECOND, word);
      calm  <= (p == 1);
      count = 0;
      while (count < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          rnd = {$urandom, $urandom};
          send_sample(rnd[cfc_pkg::IN_W-1:0], k == len - 1);
          count++;
          if ($urandom_range(0, 49) == 0) settle();
        end
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cfc_pkg.sv
hw/rtl/cfc_ctrl.sv
hw/rtl/cfc_datapath.sv
hw/rtl/cascaded_fir_convolution.sv
test/cfc_check_pkg.sv
test/cascaded_fir_convolution_test.sv
